// ===== hdl/fis_pkg.sv =====
package fis_pkg;

	// Window depth and the widths that follow from it.
	localparam int WINDOW = 60;
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int PTR_W  = $clog2(WINDOW);
	localparam int SUM_W  = 32 + CNT_W;
	localparam int RATE_W = 40;
	localparam int NUM_W  = RATE_W + CNT_W;
	localparam int PAD_W  = NUM_W - SUM_W;
	localparam int ITER_W = $clog2(NUM_W + 1);

	// Item kinds.
	localparam logic [1:0] KIND_MARK  = 2'd0;
	localparam logic [1:0] KIND_FRAME = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_APPLY,
		S_CUR_LOAD,
		S_CUR_RUN,
		S_AVT_LOAD,
		S_AVT_RUN,
		S_AVR_LOAD,
		S_AVR_RUN,
		S_DONE
	} state_t;

endpackage

// ===== hdl/frame_interval_statistics.sv =====
// Frame interval statistics monitor.
//
// Input channel (in_valid/in_ready, kind, timestamp): one item per event. A mark
// item loads the reference time, a frame-end item records the interval since the
// reference, a clear item resets the statistics and the interval window.
// Output channel (out_valid/out_ready): one result item per input item, holding
// the statistics after that item has been applied.
// Configuration channel (cfg_valid/cfg_ready, cfg_data): writes tick_rate; it is
// always ready. The user must write it only while the block is idle; the block does not enforce this.
//
// The window is one synchronous memory, read on accept and written back in the
// cycle after. The three quotients share one restoring divider that retires
// one quotient bit per cycle, so the divider sets the rate. The next item is
// taken in the cycle after the result is registered.
// If the receiver stalls, the result waits in the output register while the
// next item is already accepted and processed; that item then holds before
// its own result until the register is free.
// Reset clears the statistics, the window valid bits, the reference time and
// the current rate, and loads tick_rate with 1000000.
module frame_interval_statistics import fis_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [31:0] timestamp,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [39:0] current_rate,
	output logic [39:0] average_rate,
	output logic [31:0] average_ticks,
	output logic [31:0] min_ticks,
	output logic [31:0] max_ticks,
	output logic [47:0] frames_seen,
	output logic [63:0] elapsed_ticks
);

	state_t state_q, state_d;

	logic [31:0]       tick_rate_q;
	logic [1:0]        kind_q;
	logic [31:0]       stamp_q;

	logic [31:0]       ring_mem [WINDOW];
	logic [31:0]       ring_rd_q;
	logic [WINDOW-1:0] ring_valid_q;

	logic [PTR_W-1:0]  ptr_q;
	logic [SUM_W-1:0]  total_q;
	logic [31:0]       ref_q;
	logic [31:0]       shortest_q;
	logic [31:0]       longest_q;
	logic [47:0]       tally_q;
	logic [63:0]       running_q;
	logic [39:0]       last_rate_q;
	logic [31:0]       frame_t_q;
	logic [31:0]       avg_ticks_q;
	logic [39:0]       avg_rate_q;

	logic [NUM_W-1:0]  dvd_q;
	logic [SUM_W-1:0]  rem_q;
	logic [SUM_W-1:0]  dvs_q;
	logic [ITER_W-1:0] iter_q;

	logic              out_valid_q;
	logic [39:0]       cur_rate_out_q;
	logic [39:0]       avg_rate_out_q;
	logic [31:0]       avg_ticks_out_q;
	logic [31:0]       min_out_q;
	logic [31:0]       max_out_q;
	logic [47:0]       frames_out_q;
	logic [63:0]       elapsed_out_q;

	logic              in_accept;
	logic              out_free;
	logic              ready_c;
	logic              div_step;
	logic              div_last;
	logic              frame_apply;
	logic              clear_apply;
	logic [31:0]       frame_t;
	logic [31:0]       old_entry;
	logic [PTR_W-1:0]  ptr_next;
	logic [CNT_W-1:0]  win_n;
	logic [RATE_W-1:0] rate256;
	logic [NUM_W-1:0]  avr_dividend;
	logic [SUM_W:0]    trial;
	logic [SUM_W:0]    trial_diff;
	logic              trial_ge;

	// Handshake and derived values.
	assign in_accept   = in_valid && in_ready;
	assign out_free    = !out_valid_q || out_ready;
	assign frame_apply = (state_q == S_APPLY) && (kind_q == KIND_FRAME);
	assign clear_apply = (state_q == S_APPLY) && (kind_q == KIND_CLEAR);
	assign frame_t     = stamp_q - ref_q;
	assign old_entry   = ring_valid_q[ptr_q] ? ring_rd_q : 32'd0;
	assign ptr_next    = (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
	assign win_n       = (tally_q < 48'(WINDOW)) ? CNT_W'(tally_q) : CNT_W'(WINDOW);
	assign rate256     = {tick_rate_q, 8'd0};
	assign avr_dividend = NUM_W'(rate256) * NUM_W'(win_n);
	assign div_last    = (iter_q == '0);

	// One restoring step of the shared divider.
	assign trial      = {rem_q, dvd_q[NUM_W-1]};
	assign trial_ge   = trial >= {1'b0, dvs_q};
	assign trial_diff = trial - {1'b0, dvs_q};

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:     if (in_accept) state_d = S_APPLY;
			S_APPLY:    state_d = (kind_q == KIND_FRAME) ? S_CUR_LOAD : S_AVT_LOAD;
			S_CUR_LOAD: state_d = S_CUR_RUN;
			S_CUR_RUN:  if (div_last) state_d = S_AVT_LOAD;
			S_AVT_LOAD: state_d = S_AVT_RUN;
			S_AVT_RUN:  if (div_last) state_d = S_AVR_LOAD;
			S_AVR_LOAD: state_d = S_AVR_RUN;
			S_AVR_RUN:  if (div_last) state_d = S_DONE;
			S_DONE:     if (out_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		ready_c  = 1'b0;
		div_step = 1'b0;
		case (state_q)
			S_IDLE:    ready_c = 1'b1;
			S_CUR_RUN,
			S_AVT_RUN,
			S_AVR_RUN: div_step = !div_last;
			default: begin
				ready_c  = 1'b0;
				div_step = 1'b0;
			end
		endcase
	end

	assign in_ready  = ready_c;
	assign cfg_ready = 1'b1;

	// Control and statistics registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			tick_rate_q  <= 32'd1000000;
			ring_valid_q <= '0;
			ptr_q        <= '0;
			total_q      <= '0;
			ref_q        <= '0;
			shortest_q   <= '1;
			longest_q    <= '0;
			tally_q      <= '0;
			running_q    <= '0;
			last_rate_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				tick_rate_q <= cfg_data;
			end
			if ((state_q == S_APPLY) && (kind_q == KIND_MARK)) begin
				ref_q <= stamp_q;
			end
			if (frame_apply) begin
				ref_q               <= stamp_q;
				total_q             <= total_q - SUM_W'(old_entry) + SUM_W'(frame_t);
				ring_valid_q[ptr_q] <= 1'b1;
				ptr_q               <= ptr_next;
				tally_q             <= tally_q + 48'd1;
				running_q           <= running_q + 64'(frame_t);
				if (frame_t < shortest_q) shortest_q <= frame_t;
				if (frame_t > longest_q) longest_q <= frame_t;
			end
			if (clear_apply) begin
				ring_valid_q <= '0;
				ptr_q        <= '0;
				total_q      <= '0;
				shortest_q   <= '1;
				longest_q    <= '0;
				tally_q      <= '0;
				running_q    <= '0;
			end
			if ((state_q == S_CUR_RUN) && div_last) begin
				last_rate_q <= (frame_t_q == 32'd0) ? '0 : dvd_q[RATE_W-1:0];
			end
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Window memory: read on accept, written back in the apply cycle.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			ring_rd_q <= ring_mem[ptr_q];
		end
		if (frame_apply) begin
			ring_mem[ptr_q] <= frame_t;
		end
	end

	// Item capture, shared divider and result payload.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			kind_q  <= kind;
			stamp_q <= timestamp;
		end
		if (frame_apply) begin
			frame_t_q <= frame_t;
		end
		case (state_q)
			S_CUR_LOAD: begin
				dvd_q  <= {rate256, CNT_W'(0)};
				dvs_q  <= SUM_W'(frame_t_q);
				rem_q  <= '0;
				iter_q <= ITER_W'(RATE_W);
			end
			S_AVT_LOAD: begin
				dvd_q  <= {total_q, PAD_W'(0)};
				dvs_q  <= SUM_W'(win_n);
				rem_q  <= '0;
				iter_q <= ITER_W'(SUM_W);
			end
			S_AVR_LOAD: begin
				dvd_q  <= avr_dividend;
				dvs_q  <= total_q;
				rem_q  <= '0;
				iter_q <= ITER_W'(NUM_W);
			end
			default: begin
				if (div_step) begin
					rem_q  <= trial_ge ? trial_diff[SUM_W-1:0] : trial[SUM_W-1:0];
					dvd_q  <= {dvd_q[NUM_W-2:0], trial_ge};
					iter_q <= iter_q - 1'b1;
				end
			end
		endcase
		if ((state_q == S_AVT_RUN) && div_last) begin
			avg_ticks_q <= (win_n == '0) ? 32'd0 : dvd_q[31:0];
		end
		if ((state_q == S_AVR_RUN) && div_last) begin
			if (total_q == '0) begin
				avg_rate_q <= '0;
			end else if (|dvd_q[NUM_W-1:RATE_W]) begin
				avg_rate_q <= '1;
			end else begin
				avg_rate_q <= dvd_q[RATE_W-1:0];
			end
		end
		if ((state_q == S_DONE) && out_free) begin
			cur_rate_out_q  <= last_rate_q;
			avg_rate_out_q  <= avg_rate_q;
			avg_ticks_out_q <= avg_ticks_q;
			min_out_q       <= shortest_q;
			max_out_q       <= longest_q;
			frames_out_q    <= tally_q;
			elapsed_out_q   <= running_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign current_rate  = cur_rate_out_q;
	assign average_rate  = avg_rate_out_q;
	assign average_ticks = avg_ticks_out_q;
	assign min_ticks     = min_out_q;
	assign max_ticks     = max_out_q;
	assign frames_seen   = frames_out_q;
	assign elapsed_ticks = elapsed_out_q;

	// The write pointer stays inside the window.
	assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= PTR_W'(WINDOW - 1))
		else $error("window pointer out of range");

	// An accepted item is applied in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> state_q == S_APPLY)
		else $error("accepted item not applied");

	// While the window fills, the pointer tracks the frame count.
	assert property (@(posedge clk) disable iff (!arst_n)
		tally_q < 48'(WINDOW) |-> ptr_q == PTR_W'(tally_q))
		else $error("pointer and frame count disagree");

	// Once a frame has been seen, the minimum does not exceed the maximum.
	assert property (@(posedge clk) disable iff (!arst_n)
		tally_q != '0 |-> shortest_q <= longest_q)
		else $error("minimum above maximum");

	// The partial remainder stays below a nonzero divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_step && dvs_q != '0 |-> rem_q < dvs_q)
		else $error("divider remainder out of range");

endmodule
